FILE: rtl/toy_risc_instruction_executor_unit_defines.svh
// Assertion macros used by the executor back end.
`ifndef TOY_RISC_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH
`define TOY_RISC_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH

// check a property outside reset
`define TRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check a property at every edge, reset included
`define TRE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/tre_pkg.sv
// Shared types and constants of the instruction executor.
`default_nettype none
package tre_pkg;

  localparam int unsigned RegCount   = 32;
  localparam int unsigned MemWords   = 4096;
  localparam int unsigned StackDepth = 1024;
  localparam int unsigned RegAw      = $clog2(RegCount);
  localparam int unsigned MemAw      = $clog2(MemWords);
  localparam int unsigned StkAw      = $clog2(StackDepth);
  localparam int unsigned TopW       = StkAw + 1;
  localparam int unsigned QDepth     = 2;
  localparam logic [31:0] FillValue  = 32'd299792458;
  localparam logic [4:0]  EcallReg   = 5'd5;

  typedef enum logic [4:0] {
    OP_LI = 5'd0, OP_ADD = 5'd1, OP_ADDI = 5'd2, OP_SUB = 5'd3, OP_NEG = 5'd4,
    OP_DIV = 5'd5, OP_REM = 5'd6, OP_MUL = 5'd7, OP_MV = 5'd8, OP_ECALL = 5'd9,
    OP_BEQ = 5'd10, OP_BNE = 5'd11, OP_BLT = 5'd12, OP_BGT = 5'd13, OP_BLE = 5'd14,
    OP_BGE = 5'd15, OP_BEQZ = 5'd16, OP_BNEZ = 5'd17, OP_BGTZ = 5'd18,
    OP_BLEZ = 5'd19, OP_BGEZ = 5'd20, OP_JUMP = 5'd21, OP_FILL = 5'd22,
    OP_STORE = 5'd23, OP_LOAD = 5'd24, OP_CALL = 5'd25, OP_RET = 5'd26,
    OP_NOP = 5'd27
  } op_e;

  typedef enum logic [2:0] {
    CLS_ALU, CLS_DIV, CLS_IO, CLS_BR, CLS_FILL, CLS_MEM, CLS_STK, CLS_NOP
  } cls_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_ADDR = 3'd1, ST_DIVZ = 3'd2, ST_OVF = 3'd3, ST_UNF = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    IO_NONE = 3'd0, IO_INT = 3'd1, IO_FLT = 3'd2, IO_CHAR = 3'd3,
    IO_SPACE = 3'd4, IO_NL = 3'd5
  } io_kind_e;

  localparam logic [31:0] EcPrintInt = 32'd1;
  localparam logic [31:0] EcPrintFlt = 32'd2;
  localparam logic [31:0] EcPrintChr = 32'd3;
  localparam logic [31:0] EcReadInt  = 32'd4;
  localparam logic [31:0] EcReadFlt  = 32'd5;
  localparam logic [31:0] EcReadChr  = 32'd6;
  localparam logic [31:0] EcSpace    = 32'd7;
  localparam logic [31:0] EcNewline  = 32'd8;

  typedef struct packed {
    op_e         op;
    cls_e        cls;
    logic [4:0]  reg_a;
    logic [4:0]  reg_b;
    logic [4:0]  reg_c;
    logic [31:0] immediate;
    logic [11:0] instr_index;
    logic [12:0] target_index;
    logic [31:0] console_in;
  } item_t;

  typedef struct packed {
    logic [12:0] next_index;
    status_e     status;
    io_kind_e    io_kind;
    logic [31:0] io_value;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/tre_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tre_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/tre_front.sv
// Front end: accepts instruction beats, classifies them, queues them.
`default_nettype none
module tre_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire tre_pkg::item_t in_item_i,
  input  wire logic          hold_i,
  output logic               item_valid_o,
  output tre_pkg::item_t     item_o,
  input  wire logic          pop_i
);

  tre_pkg::item_t q_q [tre_pkg::QDepth];
  logic           wp_q, wp_d, rp_q, rp_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push;
  tre_pkg::item_t cls_item;

  always_comb begin
    cls_item = in_item_i;
    unique case (in_item_i.op) inside
      tre_pkg::OP_LI, tre_pkg::OP_ADD, tre_pkg::OP_ADDI, tre_pkg::OP_SUB,
      tre_pkg::OP_NEG, tre_pkg::OP_MUL, tre_pkg::OP_MV: cls_item.cls = tre_pkg::CLS_ALU;
      tre_pkg::OP_DIV, tre_pkg::OP_REM:                 cls_item.cls = tre_pkg::CLS_DIV;
      tre_pkg::OP_ECALL:                                 cls_item.cls = tre_pkg::CLS_IO;
      [tre_pkg::OP_BEQ:tre_pkg::OP_JUMP]:                cls_item.cls = tre_pkg::CLS_BR;
      tre_pkg::OP_FILL:                                  cls_item.cls = tre_pkg::CLS_FILL;
      tre_pkg::OP_STORE, tre_pkg::OP_LOAD:               cls_item.cls = tre_pkg::CLS_MEM;
      tre_pkg::OP_CALL, tre_pkg::OP_RET:                 cls_item.cls = tre_pkg::CLS_STK;
      default:                                           cls_item.cls = tre_pkg::CLS_NOP;
    endcase
  end

  assign in_ready_o   = (cnt_q != 2'(tre_pkg::QDepth)) && !hold_i;
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = q_q[rp_q];

  always_comb begin
    wp_d  = push  ? ~wp_q : wp_q;
    rp_d  = pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wp_q] <= cls_item;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tre_back.sv
// Back end: register file, data memory, return stack, divider and sequencer.
`default_nettype none
`include "toy_risc_instruction_executor_unit_defines.svh"
module tre_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            item_valid_i,
  input  wire tre_pkg::item_t  item_i,
  output logic                 pop_o,
  output logic                 busy_o,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output tre_pkg::result_t     res_o
);

  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_RB   = 10'b0000000100,
    S_RC   = 10'b0000001000,
    S_R5   = 10'b0000010000,
    S_R0   = 10'b0000100000,
    S_EXEC = 10'b0001000000,
    S_DIV  = 10'b0010000000,
    S_WAIT = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  tre_pkg::item_t cur_q;
  logic [31:0] x_q, y_q, z_q, r5_q;

  // register file
  logic [tre_pkg::RegCount-1:0] vld_q;
  logic [31:0] dflt_q;
  logic [tre_pkg::RegAw-1:0] rf_raddr, rf_ra_q;
  logic [31:0] rf_rdata, rf_rval;
  logic rf_we;

  // data memory and stack
  logic [tre_pkg::MemAw-1:0] clr_q, mem_waddr, mem_raddr;
  logic mem_we;
  logic [31:0] mem_wdata, mem_rdata;
  logic [tre_pkg::TopW-1:0] top_q, top_d;
  logic stk_we;
  logic [tre_pkg::StkAw-1:0] stk_waddr, stk_raddr;
  logic [11:0] stk_rdata;

  // divider
  logic [31:0] dv_q, dd_q, rm_q;
  logic [4:0]  dcnt_q;
  logic [32:0] dsh;
  logic        dge;
  logic [31:0] dv_n, rm_n, div_res;

  // staged result
  tre_pkg::result_t res_q, res_d, out_q;
  logic        out_valid_q;
  logic        wb_en_q, wb_en_d, fill_q, fill_d;
  logic [tre_pkg::RegAw-1:0] wb_addr_q, wb_addr_d;
  logic [31:0] wb_data_q, wb_data_d;

  // execute-stage values
  logic [32:0] maddr;
  logic        moor, take, done_go;
  logic [12:0] tgt_p1;
  logic [63:0] prod;

  assign rf_rval = vld_q[rf_ra_q] ? rf_rdata : dflt_q;
  assign busy_o  = (state_q == S_CLR);
  assign pop_o   = (state_q == S_IDLE) && item_valid_i;
  assign done_go = (state_q == S_DONE) && (!out_valid_q || res_ready_i);
  assign rf_we   = done_go && wb_en_q;

  assign maddr  = {x_q[31], x_q} + {cur_q.immediate[31], cur_q.immediate};
  assign moor   = maddr[32] || (maddr >= 33'(tre_pkg::MemWords));
  assign tgt_p1 = cur_q.target_index[12] ? 13'd0 : {1'b0, cur_q.target_index[11:0]} + 13'd1;
  assign prod   = y_q * z_q;

  assign dsh  = {rm_q, dv_q[31]};
  assign dge  = dsh >= {1'b0, dd_q};
  assign rm_n = dge ? 32'(dsh - {1'b0, dd_q}) : dsh[31:0];
  assign dv_n = {dv_q[30:0], dge};
  always_comb begin
    if (cur_q.op == tre_pkg::OP_DIV) begin
      div_res = (y_q[31] ^ z_q[31]) ? 32'd0 - dv_n : dv_n;
    end else begin
      div_res = y_q[31] ? 32'd0 - rm_n : rm_n;
    end
  end

  always_comb begin
    unique case (cur_q.op) inside
      tre_pkg::OP_BEQ:  take = (x_q == y_q);
      tre_pkg::OP_BNE:  take = (x_q != y_q);
      tre_pkg::OP_BLT:  take = ($signed(x_q) <  $signed(y_q));
      tre_pkg::OP_BGT:  take = ($signed(x_q) >  $signed(y_q));
      tre_pkg::OP_BLE:  take = ($signed(x_q) <= $signed(y_q));
      tre_pkg::OP_BGE:  take = ($signed(x_q) >= $signed(y_q));
      tre_pkg::OP_BEQZ: take = (x_q == 32'd0);
      tre_pkg::OP_BNEZ: take = (x_q != 32'd0);
      tre_pkg::OP_BGTZ: take = ($signed(x_q) > 0);
      tre_pkg::OP_BLEZ: take = ($signed(x_q) <= 0);
      tre_pkg::OP_BGEZ: take = ($signed(x_q) >= 0);
      tre_pkg::OP_JUMP: take = !cur_q.target_index[12];
      default:          take = 1'b0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    wb_en_d   = wb_en_q;
    wb_addr_d = wb_addr_q;
    wb_data_d = wb_data_q;
    fill_d    = fill_q;
    top_d     = top_q;
    rf_raddr  = cur_q.reg_a[tre_pkg::RegAw-1:0];
    mem_we    = 1'b0;
    mem_waddr = maddr[tre_pkg::MemAw-1:0];
    mem_wdata = z_q;
    mem_raddr = maddr[tre_pkg::MemAw-1:0];
    stk_we    = 1'b0;
    stk_waddr = top_q[tre_pkg::StkAw-1:0];
    stk_raddr = tre_pkg::StkAw'(top_q - tre_pkg::TopW'(1));
    unique case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 32'd0;
        if (clr_q == tre_pkg::MemAw'(tre_pkg::MemWords - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        rf_raddr = item_i.reg_a[tre_pkg::RegAw-1:0];
        if (item_valid_i) begin
          state_d = S_RB;
        end
      end
      S_RB: begin
        rf_raddr = cur_q.reg_b[tre_pkg::RegAw-1:0];
        state_d  = S_RC;
      end
      S_RC: begin
        rf_raddr = cur_q.reg_c[tre_pkg::RegAw-1:0];
        state_d  = S_R5;
      end
      S_R5: begin
        rf_raddr = tre_pkg::EcallReg[tre_pkg::RegAw-1:0];
        state_d  = S_R0;
      end
      S_R0: begin
        rf_raddr = '0;
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        state_d   = S_DONE;
        res_d     = '{next_index: {1'b0, cur_q.instr_index} + 13'd1,
                      status: tre_pkg::ST_OK, io_kind: tre_pkg::IO_NONE, io_value: 32'd0};
        wb_en_d   = 1'b0;
        fill_d    = 1'b0;
        wb_addr_d = cur_q.reg_a[tre_pkg::RegAw-1:0];
        wb_data_d = y_q;
        unique case (cur_q.cls)
          tre_pkg::CLS_ALU: begin
            wb_en_d = 1'b1;
            case (cur_q.op)
              tre_pkg::OP_LI:   wb_data_d = cur_q.immediate;
              tre_pkg::OP_ADD:  wb_data_d = y_q + z_q;
              tre_pkg::OP_ADDI: wb_data_d = y_q + cur_q.immediate;
              tre_pkg::OP_SUB:  wb_data_d = y_q - z_q;
              tre_pkg::OP_NEG:  wb_data_d = 32'd0 - y_q;
              tre_pkg::OP_MUL:  wb_data_d = prod[31:0];
              default:          wb_data_d = y_q;
            endcase
          end
          tre_pkg::CLS_DIV: begin
            if (z_q == 32'd0) begin
              res_d.status = tre_pkg::ST_DIVZ;
            end else begin
              wb_en_d = 1'b1;
              state_d = S_DIV;
            end
          end
          tre_pkg::CLS_IO: begin
            wb_addr_d = '0;
            case (r5_q)
              tre_pkg::EcPrintInt: begin
                res_d.io_kind = tre_pkg::IO_INT;
                res_d.io_value = rf_rval;
              end
              tre_pkg::EcPrintFlt: begin
                res_d.io_kind = tre_pkg::IO_FLT;
                res_d.io_value = rf_rval;
              end
              tre_pkg::EcPrintChr: begin
                res_d.io_kind = tre_pkg::IO_CHAR;
                res_d.io_value = rf_rval;
              end
              tre_pkg::EcReadInt, tre_pkg::EcReadFlt: begin
                wb_en_d   = 1'b1;
                wb_data_d = cur_q.console_in;
              end
              tre_pkg::EcReadChr: begin
                wb_en_d   = 1'b1;
                wb_data_d = {24'd0, cur_q.console_in[7:0]};
              end
              tre_pkg::EcSpace:   res_d.io_kind = tre_pkg::IO_SPACE;
              tre_pkg::EcNewline: res_d.io_kind = tre_pkg::IO_NL;
              default: ;
            endcase
          end
          tre_pkg::CLS_BR: begin
            if (take) begin
              res_d.next_index = tgt_p1;
            end
          end
          tre_pkg::CLS_FILL: fill_d = 1'b1;
          tre_pkg::CLS_MEM: begin
            wb_addr_d = cur_q.reg_b[tre_pkg::RegAw-1:0];
            if (moor) begin
              res_d.status = tre_pkg::ST_ADDR;
            end else if (cur_q.op == tre_pkg::OP_STORE) begin
              mem_we = 1'b1;
            end else begin
              wb_en_d = 1'b1;
              state_d = S_WAIT;
            end
          end
          tre_pkg::CLS_STK: begin
            if (cur_q.op == tre_pkg::OP_CALL) begin
              if (top_q == tre_pkg::TopW'(tre_pkg::StackDepth)) begin
                res_d.status = tre_pkg::ST_OVF;
              end else begin
                stk_we = 1'b1;
                top_d  = top_q + tre_pkg::TopW'(1);
                if (!cur_q.target_index[12]) begin
                  res_d.next_index = tgt_p1;
                end
              end
            end else if (top_q == '0) begin
              res_d.status = tre_pkg::ST_UNF;
            end else begin
              top_d   = top_q - tre_pkg::TopW'(1);
              state_d = S_WAIT;
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (dcnt_q == 5'd0) begin
          wb_data_d = div_res;
          state_d   = S_DONE;
        end
      end
      S_WAIT: begin
        if (cur_q.cls == tre_pkg::CLS_MEM) begin
          wb_data_d = mem_rdata;
        end else begin
          res_d.next_index = {1'b0, stk_rdata} + 13'd1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (done_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      top_q       <= '0;
      vld_q       <= '0;
      dflt_q      <= 32'd0;
      out_valid_q <= 1'b0;
      wb_en_q     <= 1'b0;
      fill_q      <= 1'b0;
      dcnt_q      <= 5'd0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      wb_en_q <= wb_en_d;
      fill_q  <= fill_d;
      if (state_q == S_CLR) begin
        clr_q <= clr_q + tre_pkg::MemAw'(1);
      end
      if (state_q == S_EXEC) begin
        dcnt_q <= 5'd31;
      end else if (state_q == S_DIV) begin
        dcnt_q <= dcnt_q - 5'd1;
      end
      if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (done_go) begin
        out_valid_q <= 1'b1;
        if (fill_q) begin
          vld_q  <= '0;
          dflt_q <= tre_pkg::FillValue;
        end else if (wb_en_q) begin
          vld_q[wb_addr_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rf_ra_q   <= rf_raddr;
    res_q     <= res_d;
    wb_addr_q <= wb_addr_d;
    wb_data_q <= wb_data_d;
    if (pop_o) begin
      cur_q <= item_i;
    end
    unique case (state_q)
      S_RB:    x_q  <= rf_rval;
      S_RC:    y_q  <= rf_rval;
      S_R5:    z_q  <= rf_rval;
      S_R0:    r5_q <= rf_rval;
      default: ;
    endcase
    if (state_q == S_EXEC) begin
      dv_q <= y_q[31] ? 32'd0 - y_q : y_q;
      dd_q <= z_q[31] ? 32'd0 - z_q : z_q;
      rm_q <= 32'd0;
    end else if (state_q == S_DIV) begin
      dv_q <= dv_n;
      rm_q <= rm_n;
    end
    if (done_go) begin
      out_q <= res_q;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  tre_ram #(.Width(32), .Depth(tre_pkg::RegCount)) u_rf (
    .clk_i, .we_i(rf_we), .waddr_i(wb_addr_q), .wdata_i(wb_data_q),
    .raddr_i(rf_raddr), .rdata_o(rf_rdata)
  );

  tre_ram #(.Width(32), .Depth(tre_pkg::MemWords)) u_dmem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );

  tre_ram #(.Width(12), .Depth(tre_pkg::StackDepth)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(cur_q.instr_index),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  `TRE_ASSERT(a_top_bound, top_q <= tre_pkg::TopW'(tre_pkg::StackDepth), "stack top past depth")
  `TRE_ASSERT(a_no_pop_clr, (state_q == S_CLR) |-> !pop_o, "item taken during memory clear")
  `TRE_ASSERT(a_div_end, (state_q == S_DIV && dcnt_q == 5'd0) |=> (state_q == S_DONE), "divider did not finish")
  `TRE_ASSERT_ALWAYS(a_out_src, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result without completion")

endmodule
`default_nettype wire

FILE: rtl/toy_risc_instruction_executor_unit.sv
// Top level of the decoded-instruction executor.
// Usage:
//   s_axis carries one decoded instruction per beat; m_axis returns one
//   result beat per instruction (next index, status, console event).
//   A front queue of two entries takes beats while the back end executes.
// Sequence, input beat to result beat valid:
//   most operations pass five register file reads through one
//   read port, execute and complete; load and return also wait on
//   the data memory or return stack read; divide and remainder wait on
//   the radix-2 divider taking 32 iterations.
// Concurrency: the back end handles one instruction at a time and takes
//   the next only after the previous result completes.
// Reset: registers read as zero at once; the data memory is cleared by a
//   sweep over all 4096 words during which s_axis_tready_o stays low.
// Stall: a result waits in the output register while m_axis_tready_i is
//   low; the back end holds the next result until it drains, and the front
//   queue keeps accepting until full.
`default_nettype none
module toy_risc_instruction_executor_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // operation[4:0], reg_a[9:5], reg_b[14:10], reg_c[19:15], immediate[51:20],
  // instr_index[63:52], target_index[76:64], console_in[108:77], zero pad
  input  wire logic [111:0] s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // next_index[12:0], status[15:13], io_value[47:16]
  output logic [47:0]       m_axis_tdata_o,
  // io_kind[2:0]
  output logic [2:0]        m_axis_tuser_o
);

  tre_pkg::item_t   in_item, q_item;
  tre_pkg::result_t res;
  logic q_valid, q_pop, hold;

  always_comb begin
    in_item              = '0;
    in_item.op           = tre_pkg::op_e'(s_axis_tdata_i[4:0]);
    in_item.reg_a        = s_axis_tdata_i[9:5];
    in_item.reg_b        = s_axis_tdata_i[14:10];
    in_item.reg_c        = s_axis_tdata_i[19:15];
    in_item.immediate    = s_axis_tdata_i[51:20];
    in_item.instr_index  = s_axis_tdata_i[63:52];
    in_item.target_index = s_axis_tdata_i[76:64];
    in_item.console_in   = s_axis_tdata_i[108:77];
  end

  tre_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o), .in_item_i(in_item),
    .hold_i(hold), .item_valid_o(q_valid), .item_o(q_item), .pop_i(q_pop)
  );

  tre_back u_back (
    .clk_i, .rst_ni,
    .item_valid_i(q_valid), .item_i(q_item), .pop_o(q_pop), .busy_o(hold),
    .res_valid_o(m_axis_tvalid_o), .res_ready_i(m_axis_tready_i), .res_o(res)
  );

  assign m_axis_tdata_o = {res.io_value, res.status, res.next_index};
  assign m_axis_tuser_o = res.io_kind;

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for the decoded-instruction executor, checked against a built-in predictor.
`timescale 1ns / 1ps
`default_nettype none

module tb;

  typedef struct packed {
    bit [4:0]  op;
    bit [4:0]  a;
    bit [4:0]  b;
    bit [4:0]  c;
    bit [31:0] imm;
    bit [11:0] idx;
    bit [12:0] tgt;
    bit [31:0] cin;
  } instr_t;

  typedef struct packed {
    bit [12:0] nxt;
    bit [2:0]  status;
    bit [2:0]  kind;
    bit [31:0] value;
  } outcome_t;

  class exec_scoreboard;
    bit [31:0] regs[tre_pkg::RegCount];
    bit [31:0] mem[tre_pkg::MemWords];
    bit [11:0] stk[tre_pkg::StackDepth];
    int        depth;
    outcome_t  pending_q[$];
    int        mismatches;
    int        results;
    int        status_seen[8];
    int        kind_seen[8];

    function void note_instr(instr_t t);
      bit [31:0] x, y, z, n, d, q, r;
      longint    sa, sb, nxt, addr;
      bit        take;
      outcome_t  o;
      x = regs[t.a]; y = regs[t.b]; z = regs[t.c];
      sa = longint'($signed(x)); sb = longint'($signed(y));
      nxt = t.idx + 1;
      take = 0;
      o.status = tre_pkg::ST_OK; o.kind = tre_pkg::IO_NONE; o.value = '0;
      case (t.op)
        tre_pkg::OP_LI:   regs[t.a] = t.imm;
        tre_pkg::OP_ADD:  regs[t.a] = y + z;
        tre_pkg::OP_ADDI: regs[t.a] = y + t.imm;
        tre_pkg::OP_SUB:  regs[t.a] = y - z;
        tre_pkg::OP_NEG:  regs[t.a] = -y;
        tre_pkg::OP_DIV, tre_pkg::OP_REM: begin
          if (z == 0) begin
            o.status = tre_pkg::ST_DIVZ;
          end else begin
            n = y[31] ? -y : y;
            d = z[31] ? -z : z;
            q = n / d; r = n % d;
            if (t.op == tre_pkg::OP_DIV) regs[t.a] = (y[31] ^ z[31]) ? -q : q;
            else regs[t.a] = y[31] ? -r : r;
          end
        end
        tre_pkg::OP_MUL:  regs[t.a] = y * z;
        tre_pkg::OP_MV:   regs[t.a] = y;
        tre_pkg::OP_ECALL: begin
          case (regs[tre_pkg::EcallReg])
            tre_pkg::EcPrintInt: begin o.kind = tre_pkg::IO_INT;  o.value = regs[0]; end
            tre_pkg::EcPrintFlt: begin o.kind = tre_pkg::IO_FLT;  o.value = regs[0]; end
            tre_pkg::EcPrintChr: begin o.kind = tre_pkg::IO_CHAR; o.value = regs[0]; end
            tre_pkg::EcReadInt, tre_pkg::EcReadFlt: regs[0] = t.cin;
            tre_pkg::EcReadChr: regs[0] = {24'd0, t.cin[7:0]};
            tre_pkg::EcSpace:   o.kind = tre_pkg::IO_SPACE;
            tre_pkg::EcNewline: o.kind = tre_pkg::IO_NL;
            default: ;
          endcase
        end
        tre_pkg::OP_BEQ:  take = (x == y);
        tre_pkg::OP_BNE:  take = (x != y);
        tre_pkg::OP_BLT:  take = (sa < sb);
        tre_pkg::OP_BGT:  take = (sa > sb);
        tre_pkg::OP_BLE:  take = (sa <= sb);
        tre_pkg::OP_BGE:  take = (sa >= sb);
        tre_pkg::OP_BEQZ: take = (sa == 0);
        tre_pkg::OP_BNEZ: take = (sa != 0);
        tre_pkg::OP_BGTZ: take = (sa > 0);
        tre_pkg::OP_BLEZ: take = (sa <= 0);
        tre_pkg::OP_BGEZ: take = (sa >= 0);
        tre_pkg::OP_JUMP: if (!t.tgt[12]) nxt = t.tgt + 1;
        tre_pkg::OP_FILL: foreach (regs[i]) regs[i] = tre_pkg::FillValue;
        tre_pkg::OP_STORE, tre_pkg::OP_LOAD: begin
          addr = sa + longint'($signed(t.imm));
          if (addr < 0 || addr >= tre_pkg::MemWords) o.status = tre_pkg::ST_ADDR;
          else if (t.op == tre_pkg::OP_STORE) mem[addr] = z;
          else regs[t.b] = mem[addr];
        end
        tre_pkg::OP_CALL: begin
          if (depth >= tre_pkg::StackDepth) begin
            o.status = tre_pkg::ST_OVF;
          end else begin
            stk[depth] = t.idx;
            depth++;
            if (!t.tgt[12]) nxt = t.tgt + 1;
          end
        end
        tre_pkg::OP_RET: begin
          if (depth == 0) begin
            o.status = tre_pkg::ST_UNF;
          end else begin
            depth--;
            nxt = stk[depth] + 1;
          end
        end
        default: ;
      endcase
      if (take) nxt = t.tgt[12] ? 0 : t.tgt + 1;
      if (nxt > 4096) nxt = 4096;
      o.nxt = nxt[12:0];
      pending_q.push_back(o);
    endfunction

    function void check_result(outcome_t got);
      outcome_t e;
      results++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: next %0d", got.nxt);
        return;
      end
      e = pending_q.pop_front();
      status_seen[e.status]++;
      kind_seen[e.kind]++;
      if (got != e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at result %0d: exp next %0d st %0d io %0d/%h, got %0d %0d %0d/%h",
                   results, e.nxt, e.status, e.kind, e.value,
                   got.nxt, got.status, got.kind, got.value);
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid_i = 0;
  logic         s_axis_tready_o;
  logic [111:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 0;
  logic [47:0]  m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;

  exec_scoreboard sb = new();
  longint cycles = 0;
  int     accepted = 0;
  bit     hold_done = 0;

  toy_risc_instruction_executor_unit dut (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // check result beats
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result('{m_axis_tdata_o[12:0], m_axis_tdata_o[15:13],
                        m_axis_tuser_o, m_axis_tdata_o[47:16]});
  end

  // stall the result side on a changing pattern, with one long hold-off
  initial begin
    int mode;
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 120)) begin
        if (!hold_done && accepted > 300) begin
          hold_done = 1;
          m_axis_tready_i <= 0;
          repeat (600) @(posedge clk_i);
        end
        case (mode)
          0, 1:    m_axis_tready_i <= 1;
          2:       m_axis_tready_i <= 1'($urandom_range(0, 1));
          default: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  int burst_left = 0;

  task automatic send_instr(instr_t t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= {3'd0, t.cin, t.tgt, t.idx, t.imm, t.c, t.b, t.a, t.op};
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
    sb.note_instr(t);
    accepted++;
  endtask

  function automatic instr_t plain(bit [4:0] op, bit [4:0] a, bit [4:0] b, bit [4:0] c,
                                   bit [31:0] imm);
    instr_t t;
    t.op = op; t.a = a; t.b = b; t.c = c; t.imm = imm;
    t.idx = 12'($urandom_range(0, 4095));
    t.tgt = 13'($urandom_range(0, 4095));
    t.cin = $urandom();
    return t;
  endfunction

  function automatic bit [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 0;
      4: return $urandom_range(0, 9);
      5: return -$urandom_range(1, 9);
      default: return $urandom();
    endcase
  endfunction

  function automatic instr_t random_instr();
    instr_t t;
    longint want, off;
    int     sel;
    t = plain(5'($urandom_range(0, 31)), 5'($urandom()), 5'($urandom()), 5'($urandom()),
              pick_value());
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      t.op = tre_pkg::OP_LI;
      if ($urandom_range(0, 1)) begin
        t.a = tre_pkg::EcallReg; t.imm = $urandom_range(0, 9);
      end
    end else if (sel < 22) begin
      t.op = tre_pkg::OP_ECALL;
    end else if (sel < 40) begin
      t.op = $urandom_range(0, 1) ? tre_pkg::OP_STORE : tre_pkg::OP_LOAD;
      want = ($urandom_range(0, 5) == 0) ? longint'($urandom_range(0, 20)) - 10 + 4091 * $urandom_range(0, 1)
                                         : longint'($urandom_range(0, 4095));
      off = want - longint'($signed(sb.regs[t.a]));
      if (off >= -(64'sd1 <<< 31) && off < (64'sd1 <<< 31) && $urandom_range(0, 7) != 0)
        t.imm = off[31:0];
    end else if (sel < 48) begin
      t.op = $urandom_range(0, 1) ? tre_pkg::OP_CALL : tre_pkg::OP_RET;
    end
    case ($urandom_range(0, 9))
      0: t.tgt = 13'($urandom_range(4096, 8191));
      1: t.tgt = 13'd4095;
      default: ;
    endcase
    if ($urandom_range(0, 19) == 0) t.idx = 12'd4095;
    return t;
  endfunction

  initial begin
    instr_t t;
    int     n_random;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;

    // directed corners
    send_instr(plain(tre_pkg::OP_RET, 0, 0, 0, 0));
    send_instr(plain(tre_pkg::OP_LOAD, 3, 4, 0, 32'd4095));
    send_instr(plain(tre_pkg::OP_STORE, 0, 0, 0, 32'd4096));
    send_instr(plain(tre_pkg::OP_STORE, 0, 0, 0, 32'hffff_ffff));
    send_instr(plain(tre_pkg::OP_LI, 1, 0, 0, 32'h8000_0000));
    send_instr(plain(tre_pkg::OP_LI, 2, 0, 0, 32'hffff_ffff));
    send_instr(plain(tre_pkg::OP_DIV, 3, 1, 2, 0));
    send_instr(plain(tre_pkg::OP_REM, 4, 1, 2, 0));
    send_instr(plain(tre_pkg::OP_DIV, 3, 1, 0, 0));
    send_instr(plain(tre_pkg::OP_REM, 3, 2, 0, 0));
    send_instr(plain(tre_pkg::OP_STORE, 0, 0, 1, 32'd4095));
    send_instr(plain(tre_pkg::OP_LOAD, 0, 6, 0, 32'd4095));
    for (int k = int'(tre_pkg::EcPrintInt); k <= int'(tre_pkg::EcNewline) + 1; k++) begin
      send_instr(plain(tre_pkg::OP_LI, tre_pkg::EcallReg, 0, 0, 32'(k)));
      send_instr(plain(tre_pkg::OP_ECALL, 0, 0, 0, 0));
    end
    t = plain(tre_pkg::OP_JUMP, 0, 0, 0, 0); t.tgt = 13'h1fff; send_instr(t);
    t = plain(tre_pkg::OP_BEQZ, 7, 0, 0, 0); t.tgt = 13'h1fff; send_instr(t);
    t = plain(tre_pkg::OP_BGEZ, 7, 0, 0, 0); t.tgt = 13'd4095; send_instr(t);
    t = plain(tre_pkg::OP_NOP, 0, 0, 0, 0); t.idx = 12'd4095; send_instr(t);
    send_instr(plain(tre_pkg::OP_FILL, 0, 0, 0, 0));
    for (int op = 0; op <= 31; op++) send_instr(plain(5'(op), 5'($urandom()), 5'($urandom()),
                                                      5'($urandom()), pick_value()));
    // fill the return stack past its depth, then unwind part of it
    repeat (tre_pkg::StackDepth + 1) send_instr(plain(tre_pkg::OP_CALL, 0, 0, 0, 0));
    repeat (20) send_instr(plain(tre_pkg::OP_RET, 0, 0, 0, 0));

    n_random = 640;
    repeat (n_random) send_instr(random_instr());
    s_axis_tvalid_i <= 0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("covered %0d instructions, %0d results; status counts ok %0d addr %0d divz %0d",
             accepted, sb.results, sb.status_seen[tre_pkg::ST_OK],
             sb.status_seen[tre_pkg::ST_ADDR], sb.status_seen[tre_pkg::ST_DIVZ]);
    $display("overflow %0d underflow %0d, console events int %0d float %0d char %0d",
             sb.status_seen[tre_pkg::ST_OVF], sb.status_seen[tre_pkg::ST_UNF],
             sb.kind_seen[tre_pkg::IO_INT], sb.kind_seen[tre_pkg::IO_FLT],
             sb.kind_seen[tre_pkg::IO_CHAR]);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
